[design/midpoint_circle_rasterizer_top_assert.svh]
// ----------------------------------------------------------------------------
// Midpoint circle rasterizer assertion macros
// Shared wrappers that clock every check on clk_i and mute it during reset.
// ----------------------------------------------------------------------------
`ifndef MIDPOINT_CIRCLE_RASTERIZER_TOP_ASSERT_SVH
`define MIDPOINT_CIRCLE_RASTERIZER_TOP_ASSERT_SVH

// Property that must hold in the same cycle as its trigger.
`define MCR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Implication checked in the cycle after the antecedent.
`define MCR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/mcr_pkg.sv]
// ----------------------------------------------------------------------------
// Midpoint circle rasterizer package
// Widths, reset constants, register codes and the request record.
// ----------------------------------------------------------------------------
`default_nettype none

package mcr_pkg;

  localparam int CoordW   = 10;   // centre coordinates
  localparam int RadiusW  = 7;    // radius and step offsets
  localparam int ColorW   = 16;   // RGB565 colour
  localparam int ClipW    = 10;   // clip registers
  localparam int MaskW    = 8;    // eight mirrored points
  localparam int DecW     = 10;   // decision term
  localparam int IncW     = 9;    // x and y increments
  localparam int PointW   = 12;   // signed point coordinate, centre plus or minus offset
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 10;

  localparam int MaxRadiusDefault = 84;
  localparam int QDepth           = 2;

  localparam logic [ClipW-1:0] ClipWidthReset  = ClipW'(300);
  localparam logic [ClipW-1:0] ClipHeightReset = ClipW'(200);

  // Points drawn on the first step of a circle: the four cardinal points.
  localparam logic [MaskW-1:0] CardinalMask = 8'h35;
  // Points that the first step never draws.
  localparam logic [MaskW-1:0] DiagonalMask = 8'hCA;

  typedef enum logic [CfgIdxW-1:0] {
    CfgClipWidth  = 1'b0,
    CfgClipHeight = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [CoordW-1:0]  center_x;
    logic [CoordW-1:0]  center_y;
    logic [RadiusW-1:0] radius;
    logic               erase;
    logic [ColorW-1:0]  pen_color;
  } req_t;

  // Head of the request queue as seen by the walker.
  typedef struct packed {
    logic valid;
    req_t req;
  } head_t;

endpackage

`default_nettype wire

[design/mcr_if.sv]
// ----------------------------------------------------------------------------
// Midpoint circle rasterizer channels
// Valid/ready interfaces for the request, result and register write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface mcr_in_if import mcr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CoordW-1:0]  center_x;
  logic [CoordW-1:0]  center_y;
  logic [RadiusW-1:0] radius;
  logic               erase;
  logic [ColorW-1:0]  pen_color;

  modport source (output valid, center_x, center_y, radius, erase, pen_color,
                  input ready);
  modport sink   (input valid, center_x, center_y, radius, erase, pen_color,
                  output ready);
endinterface

interface mcr_out_if import mcr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CoordW-1:0]  center_x_out;
  logic [CoordW-1:0]  center_y_out;
  logic [RadiusW-1:0] offset_a;
  logic [RadiusW-1:0] offset_b;
  logic [MaskW-1:0]   point_mask;
  logic               erase_out;
  logic [ColorW-1:0]  color_out;
  logic               last;

  modport source (output valid, center_x_out, center_y_out, offset_a, offset_b,
                  point_mask, erase_out, color_out, last, input ready);
  modport sink   (input valid, center_x_out, center_y_out, offset_a, offset_b,
                  point_mask, erase_out, color_out, last, output ready);
endinterface

interface mcr_cfg_if import mcr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[design/mcr_front.sv]
// ----------------------------------------------------------------------------
// Midpoint circle rasterizer front end
// Accepts requests, saturates the radius and holds them in a short queue.
// ----------------------------------------------------------------------------
`default_nettype none

module mcr_front import mcr_pkg::*; #(
  parameter int MaxRadius = MaxRadiusDefault
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  mcr_in_if.sink      in_i,
  output head_t       head_o,
  input  logic        pop_i
);

  localparam int PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int CntW = $clog2(QDepth + 1);

  req_t               mem_q [QDepth];
  logic [PtrW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]    count_q, count_d;
  logic               push;
  req_t               req_in;

  assign in_i.ready = (count_q != CntW'(QDepth));
  assign push       = in_i.valid && in_i.ready;

  // Radii beyond the supported maximum are clamped on entry.
  always_comb begin
    req_in.center_x  = in_i.center_x;
    req_in.center_y  = in_i.center_y;
    req_in.erase     = in_i.erase;
    req_in.pen_color = in_i.pen_color;
    if (in_i.radius > RadiusW'(MaxRadius)) begin
      req_in.radius = RadiusW'(MaxRadius);
    end else begin
      req_in.radius = in_i.radius;
    end
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    priority if (push && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= req_in;
    end
  end

  assign head_o.valid = (count_q != '0);
  assign head_o.req   = mem_q[rd_ptr_q];

endmodule

`default_nettype wire

[design/mcr_walker.sv]
// ----------------------------------------------------------------------------
// Midpoint circle rasterizer walker
// Steps the midpoint recurrence, clips the eight mirrored points per step.
// ----------------------------------------------------------------------------
`default_nettype none

module mcr_walker import mcr_pkg::*; (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  head_t             head_i,
  output logic              pop_o,
  input  logic [ClipW-1:0]  clip_width_i,
  input  logic [ClipW-1:0]  clip_height_i,
  mcr_out_if.source         out_o
);

  // Walk state.
  logic                      busy_q;
  logic                      first_q;
  logic signed [DecW-1:0]    dec_q;
  logic signed [IncW-1:0]    ddx_q;
  logic signed [IncW-1:0]    ddy_q;
  logic [RadiusW-1:0]        ox_q;
  logic [RadiusW-1:0]        oy_q;
  logic [CoordW-1:0]         cx_q;
  logic [CoordW-1:0]         cy_q;
  logic                      erase_q;
  logic [ColorW-1:0]         color_q;

  // Output register.
  logic                      ov_q;
  logic [CoordW-1:0]         o_cx_q;
  logic [CoordW-1:0]         o_cy_q;
  logic [RadiusW-1:0]        o_ox_q;
  logic [RadiusW-1:0]        o_oy_q;
  logic [MaskW-1:0]          o_mask_q;
  logic                      o_erase_q;
  logic [ColorW-1:0]         o_color_q;
  logic                      o_last_q;

  logic                      emit_en;
  logic                      load_en;
  logic                      last_now;
  logic                      step_down;
  logic signed [IncW-1:0]    ddx_n;
  logic signed [IncW-1:0]    ddy_n;
  logic signed [DecW-1:0]    dec_n;
  logic signed [DecW-1:0]    dec_init;
  logic signed [IncW-1:0]    ddy_init;
  logic signed [PointW-1:0]  cx_s, cy_s, ox_s, oy_s;
  logic signed [PointW-1:0]  px [MaskW];
  logic signed [PointW-1:0]  py [MaskW];
  logic [MaskW-1:0]          in_clip;
  logic [MaskW-1:0]          mask_now;

  assign last_now = !(ox_q < oy_q);
  assign emit_en  = busy_q && (!ov_q || out_o.ready);
  assign load_en  = head_i.valid && (!busy_q || (emit_en && last_now));
  assign pop_o    = load_en;

  // Point coordinates in the fixed octant order.
  always_comb begin
    cx_s = PointW'(cx_q);
    cy_s = PointW'(cy_q);
    ox_s = PointW'(ox_q);
    oy_s = PointW'(oy_q);
    px[0] = cx_s + ox_s;  py[0] = cy_s + oy_s;
    px[1] = cx_s - ox_s;  py[1] = cy_s + oy_s;
    px[2] = cx_s + ox_s;  py[2] = cy_s - oy_s;
    px[3] = cx_s - ox_s;  py[3] = cy_s - oy_s;
    px[4] = cx_s + oy_s;  py[4] = cy_s + ox_s;
    px[5] = cx_s - oy_s;  py[5] = cy_s + ox_s;
    px[6] = cx_s + oy_s;  py[6] = cy_s - ox_s;
    px[7] = cx_s - oy_s;  py[7] = cy_s - ox_s;
    for (int i = 0; i < MaskW; i++) begin
      in_clip[i] = !px[i][PointW-1] && !py[i][PointW-1]
                && ($unsigned(px[i]) < PointW'(clip_width_i))
                && ($unsigned(py[i]) < PointW'(clip_height_i));
    end
    mask_now = first_q ? (in_clip & CardinalMask) : in_clip;
  end

  // One step of the recurrence.
  always_comb begin
    step_down = !dec_q[DecW-1];
    ddy_n     = step_down ? ddy_q + IncW'(2) : ddy_q;
    ddx_n     = ddx_q + IncW'(2);
    dec_n     = dec_q + (step_down ? DecW'(ddy_n) : '0) + DecW'(ddx_n);
    dec_init  = DecW'(1) - DecW'(head_i.req.radius);
    ddy_init  = IncW'(0) - IncW'({head_i.req.radius, 1'b0});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      if (load_en) begin
        busy_q <= 1'b1;
      end else if (emit_en && last_now) begin
        busy_q <= 1'b0;
      end
      if (emit_en) begin
        ov_q <= 1'b1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_en) begin
      first_q <= 1'b1;
      dec_q   <= dec_init;
      ddx_q   <= IncW'(1);
      ddy_q   <= ddy_init;
      ox_q    <= '0;
      oy_q    <= head_i.req.radius;
      cx_q    <= head_i.req.center_x;
      cy_q    <= head_i.req.center_y;
      erase_q <= head_i.req.erase;
      color_q <= head_i.req.pen_color;
    end else if (emit_en) begin
      first_q <= 1'b0;
      dec_q   <= dec_n;
      ddx_q   <= ddx_n;
      ddy_q   <= ddy_n;
      ox_q    <= ox_q + 1'b1;
      oy_q    <= step_down ? oy_q - 1'b1 : oy_q;
    end
    if (emit_en) begin
      o_cx_q    <= cx_q;
      o_cy_q    <= cy_q;
      o_ox_q    <= ox_q;
      o_oy_q    <= oy_q;
      o_mask_q  <= mask_now;
      o_erase_q <= erase_q;
      o_color_q <= color_q;
      o_last_q  <= last_now;
    end
  end

  assign out_o.valid        = ov_q;
  assign out_o.center_x_out = o_cx_q;
  assign out_o.center_y_out = o_cy_q;
  assign out_o.offset_a     = o_ox_q;
  assign out_o.offset_b     = o_oy_q;
  assign out_o.point_mask   = o_mask_q;
  assign out_o.erase_out    = o_erase_q;
  assign out_o.color_out    = o_color_q;
  assign out_o.last         = o_last_q;

endmodule

`default_nettype wire

[design/midpoint_circle_rasterizer_top.sv]
// ----------------------------------------------------------------------------
// Midpoint circle rasterizer
// Turns circle requests into per-step offsets with an eight-point clip mask.
// ----------------------------------------------------------------------------
// Usage. A circle request (centre, radius, erase flag, colour) is one beat on
// in_i. Each beat on out_o is one step of the midpoint walk: the offsets, a
// mask of which of the eight mirrored points fall inside the clip area, the
// centre, erase flag and colour passed on, and last on the final step.
// The clip registers are written through cfg_i (index 0 width, 1 height),
// which is always ready; write them only while no circle is in flight.
// A taken request passes through the queue and the walker state, and its
// first step reaches out_o from the output register. A circle of radius r
// (clamped to MaxRadius) gives about r/sqrt(2) + 1 beats, one per cycle while
// out_o.ready is high, so at most 61 beats for radius 84; the rate is set by
// the walker, which retires one step of the recurrence a cycle unless stalled.
// Requests queue in a two-entry buffer, and while out_o.ready is high the
// first step of a queued circle follows the last step of the previous one
// in the very next cycle. Reset clears the queue, the walker and the output
// valid, and sets the clip registers to 300 by 200. When the receiver holds
// out_o.ready low, the beat on show is kept stable, the walker pauses and the
// queue fills, after which in_i.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

`include "midpoint_circle_rasterizer_top_assert.svh"

module midpoint_circle_rasterizer_top import mcr_pkg::*; #(
  parameter int MaxRadius = MaxRadiusDefault
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  mcr_in_if.sink      in_i,
  mcr_out_if.source   out_o,
  mcr_cfg_if.sink     cfg_i
);

  logic [ClipW-1:0] clip_width_q;
  logic [ClipW-1:0] clip_height_q;
  head_t            head;
  logic             pop;

  // Register writes are always taken; an index decodes to one of two clips.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_width_q  <= ClipWidthReset;
      clip_height_q <= ClipHeightReset;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        CfgClipWidth:  clip_width_q  <= cfg_i.data;
        CfgClipHeight: clip_height_q <= cfg_i.data;
        default:       clip_width_q  <= clip_width_q;
      endcase
    end
  end

  // Front end: takes requests, clamps the radius and buffers them.
  mcr_front #(
    .MaxRadius (MaxRadius)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .head_o (head),
    .pop_i  (pop)
  );

  // Back end: walks one circle at a time into the output register.
  mcr_walker u_walker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .pop_o         (pop),
    .clip_width_i  (clip_width_q),
    .clip_height_i (clip_height_q),
    .out_o         (out_o)
  );

  // Every step before the last stays strictly below the diagonal.
  `MCR_ASSERT(a_offsets_ordered, !(out_o.valid && !out_o.last) || (out_o.offset_a < out_o.offset_b), "non-final step has offset_a not below offset_b")
  // The major offset never exceeds the clamped radius.
  `MCR_ASSERT(a_radius_clamped, !out_o.valid || (out_o.offset_b <= RadiusW'(MaxRadius)), "offset_b beyond the maximum radius")
  // A step with zero minor offset draws only the cardinal points.
  `MCR_ASSERT(a_first_cardinal, !(out_o.valid && (out_o.offset_a == '0)) || ((out_o.point_mask & DiagonalMask) == '0), "first step carries a diagonal point")
  // A beat on show is not withdrawn while the receiver stalls.
  `MCR_ASSERT_NEXT(a_hold, out_o.valid && !out_o.ready, out_o.valid, "step beat dropped while the receiver stalls")

endmodule

`default_nettype wire
